>>> design/mbp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the MSB-first bit packer.
// Used by mbp_front, mbp_cmd_fifo, mbp_back and msb_first_bit_packer.
package mbp_pkg;

  localparam int unsigned VALUE_BITS     = 32;
  localparam int unsigned BYTE_BITS      = 8;
  localparam int unsigned MAX_FIELD_BITS = 32;
  localparam int unsigned CMD_DEPTH      = 2;

  // Working window: up to seven pending bits plus one full field.
  localparam int unsigned WORD_BITS = VALUE_BITS + BYTE_BITS;
  localparam int unsigned PEND_W    = $clog2(WORD_BITS);
  localparam int unsigned COUNT_W   = 6;

  typedef enum logic {
    ACT_APPEND = 1'b0,
    ACT_FLUSH  = 1'b1
  } action_t;

  // One command for the back end: value is already left aligned.
  typedef struct packed {
    action_t                 action;
    logic [VALUE_BITS-1:0]   value_al;
    logic [COUNT_W-1:0]      count;
  } cmd_t;

  typedef struct packed {
    logic [PEND_W-1:0] pend_bits;
  } bk_status_t;

endpackage

>>> design/mbp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: saturates the bit count, left-aligns the field value and
// drops appends that carry no bits. Depends on mbp_pkg.
module mbp_front (
  input  wire logic                            push,
  input  wire logic                            q_full,
  input  wire logic                            in_action,
  input  wire logic [mbp_pkg::VALUE_BITS-1:0]  in_field_value,
  input  wire logic [mbp_pkg::COUNT_W-1:0]     in_bit_count,
  output logic                                 q_push,
  output mbp_pkg::cmd_t                        q_cmd
);

  localparam int unsigned LIMIT = (mbp_pkg::MAX_FIELD_BITS < mbp_pkg::VALUE_BITS) ?
                                  mbp_pkg::MAX_FIELD_BITS : mbp_pkg::VALUE_BITS;
  localparam logic [mbp_pkg::COUNT_W-1:0] LIMIT_C = mbp_pkg::COUNT_W'(LIMIT);
  localparam logic [mbp_pkg::COUNT_W-1:0] VBITS_C = mbp_pkg::COUNT_W'(mbp_pkg::VALUE_BITS);

  logic [mbp_pkg::COUNT_W-1:0] count_sat;
  logic [mbp_pkg::COUNT_W-1:0] align_sh;
  logic                        is_flush;

  always_comb begin
    is_flush  = (mbp_pkg::action_t'(in_action) == mbp_pkg::ACT_FLUSH);
    count_sat = (in_bit_count > LIMIT_C) ? LIMIT_C : in_bit_count;
    align_sh  = VBITS_C - count_sat;
    q_cmd.action   = mbp_pkg::action_t'(in_action);
    // Shift out the ignored upper bits; a shift of the full width gives zero.
    q_cmd.value_al = in_field_value << align_sh;
    q_cmd.count    = count_sat;
    // Drop appends of zero bits: they change nothing.
    q_push = push && !q_full && (is_flush || (count_sat != '0));
  end

endmodule
`default_nettype wire

>>> design/mbp_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// Short command queue between the front and back ends.
// Depends on mbp_pkg for the command type.
module mbp_cmd_fifo #(
  parameter int unsigned DEPTH = mbp_pkg::CMD_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  mbp_pkg::cmd_t      wr_cmd,
  input  wire logic          rd_en,
  output mbp_pkg::cmd_t      rd_cmd,
  output logic               rd_valid,
  output logic               full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  mbp_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  always_comb begin
    do_wr      = wr_en && (cnt_r != DEPTH_C);
    do_rd      = rd_en && (cnt_r != '0);
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  assign rd_cmd   = mem_r[rd_ptr_r];
  assign rd_valid = (cnt_r != '0);
  assign full     = (cnt_r == DEPTH_C);

endmodule
`default_nettype wire

>>> design/mbp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: merges commands into a left-aligned bit window and emits one
// byte per cycle to a free or popped output register. Depends on mbp_pkg.
module mbp_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  mbp_pkg::cmd_t              cmd,
  input  wire logic                  cmd_valid,
  output logic                       cmd_pop,
  input  wire logic                  pop,
  output logic                       empty,
  output logic [7:0]                 out_byte_out,
  output logic                       out_last,
  output mbp_pkg::bk_status_t        status
);

  localparam int unsigned WB = mbp_pkg::WORD_BITS;
  localparam int unsigned PW = mbp_pkg::PEND_W;
  localparam logic [PW-1:0] BYTE_C = PW'(mbp_pkg::BYTE_BITS);
  localparam logic [PW-1:0] TWO_BYTE_C = PW'(2 * mbp_pkg::BYTE_BITS);

  // Pending bits sit at the top of word_r; bits below pend_r are zero.
  logic [WB-1:0] word_r, word_nxt;
  logic [PW-1:0] pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;

  logic          emit;
  logic          load;
  logic [WB-1:0] base_word;
  logic [PW-1:0] base_pend;
  logic [WB-1:0] ins_word;

  always_comb begin
    emit      = (pend_r >= BYTE_C) && (!out_valid_r || pop);
    base_word = emit ? (word_r << mbp_pkg::BYTE_BITS) : word_r;
    base_pend = emit ? (pend_r - BYTE_C) : pend_r;
    // Take the next command once no full byte remains after this cycle.
    load      = cmd_valid && (base_pend < BYTE_C);
    ins_word  = {cmd.value_al, 8'h00} >> base_pend[2:0];

    word_nxt = base_word;
    pend_nxt = base_pend;
    if (load) begin
      unique case (cmd.action)
        mbp_pkg::ACT_FLUSH: begin
          // Pad with the zeros already below the pending bits.
          pend_nxt = (base_pend == '0) ? '0 : BYTE_C;
        end
        mbp_pkg::ACT_APPEND: begin
          word_nxt = base_word | ins_word;
          pend_nxt = base_pend + PW'(cmd.count);
        end
        default: begin
          pend_nxt = base_pend;
        end
      endcase
    end

    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = word_r[WB-1 -: 8];
      out_last_nxt  = (pend_r < TWO_BYTE_C);
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      word_r      <= word_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign cmd_pop          = load;
  assign empty            = !out_valid_r;
  assign out_byte_out     = out_byte_r;
  assign out_last         = out_last_r;
  assign status.pend_bits = pend_r;

endmodule
`default_nettype wire

>>> design/msb_first_bit_packer.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the MSB-first bit packer: front end, command queue, back end.
// Depends on mbp_pkg, mbp_front, mbp_cmd_fifo and mbp_back.

// Packs fields of 0 to 32 bits into bytes, most significant bit first, and
// pads the partial byte with zeros on a flush. Both sides are queues: push
// an item while full is low, pop a byte while empty is low; out_last marks
// the final byte of an item. The back end emits one byte per cycle while
// the output register is free or popped, and the next item loads in the
// cycle its predecessor's final byte moves to the output register. The
// first byte of an item passes from the command queue through the bit
// window word_r to the output register before it shows on the output.
module msb_first_bit_packer #(
  parameter int unsigned CMD_DEPTH = mbp_pkg::CMD_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            in_action,
  input  wire logic [mbp_pkg::VALUE_BITS-1:0]  in_field_value,
  input  wire logic [mbp_pkg::COUNT_W-1:0]     in_bit_count,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [7:0]                           out_byte_out,
  output logic                                 out_last
);

  logic                q_push;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  mbp_pkg::cmd_t       q_wr_cmd;
  mbp_pkg::cmd_t       q_rd_cmd;
  mbp_pkg::bk_status_t bk_status;

  mbp_front u_front (
    .push           (push),
    .q_full         (q_full),
    .in_action      (in_action),
    .in_field_value (in_field_value),
    .in_bit_count   (in_bit_count),
    .q_push         (q_push),
    .q_cmd          (q_wr_cmd)
  );

  mbp_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_cmd   (q_wr_cmd),
    .rd_en    (q_pop),
    .rd_cmd   (q_rd_cmd),
    .rd_valid (q_valid),
    .full     (q_full)
  );

  mbp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (q_rd_cmd),
    .cmd_valid    (q_valid),
    .cmd_pop      (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_byte_out (out_byte_out),
    .out_last     (out_last),
    .status       (bk_status)
  );

  assign full = q_full;

`ifndef ASSERT_OFF
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end took a command from an empty queue");

  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.pend_bits <= mbp_pkg::PEND_W'(mbp_pkg::WORD_BITS - 1))
    else $error("pending bit count out of range");

  a_byte_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
    (empty && (bk_status.pend_bits >= mbp_pkg::PEND_W'(mbp_pkg::BYTE_BITS)))
      |=> !empty)
    else $error("completed byte not moved to the output register");
`endif

endmodule
`default_nettype wire

>>> verif/tb_msb_first_bit_packer.sv
`timescale 1ns / 1ps
// Self-checking testbench for msb_first_bit_packer: directed and random fields and flushes.
// A behavioral packer predicts each byte, which is checked against the DUT output queue.
// Depends on mbp_pkg and the msb_first_bit_packer RTL.
module tb_msb_first_bit_packer;

  localparam int STUCK_LIMIT = 500;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           push = 1'b0;
  logic                           in_action = mbp_pkg::ACT_APPEND;
  logic [mbp_pkg::VALUE_BITS-1:0] in_field_value = '0;
  logic [mbp_pkg::COUNT_W-1:0]    in_bit_count = '0;
  logic                           pop = 1'b0;
  logic                           full;
  logic                           empty;
  logic [7:0]                     out_byte_out;
  logic                           out_last;

  // Predicted packer state and the bytes still owed by the DUT.
  logic [6:0]   pend_bits = '0;
  logic [2:0]   pend_cnt = '0;
  packed_byte_t exp_bytes[$];

  bit gaps_on = 1'b1;
  int err_count = 0;
  int stuck_cycles = 0;
  int pop_stall = 0;

  msb_first_bit_packer u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_action     (in_action),
    .in_field_value(in_field_value),
    .in_bit_count  (in_bit_count),
    .empty         (empty),
    .pop           (pop),
    .out_byte_out  (out_byte_out),
    .out_last      (out_last)
  );

  always #6 clk = ~clk;

  // Work out the bytes one accepted transaction produces and update the state.
  task automatic predict_packed_bytes(input mbp_pkg::action_t act, input logic [31:0] val,
                                      input logic [5:0] cnt);
    packed_byte_t got[4];
    logic [7:0]   acc;
    int           fill;
    int           n_bits;
    int           n;
    n = 0;
    if (act == mbp_pkg::ACT_FLUSH) begin
      if (pend_cnt != 0) begin
        got[0].data = 8'(int'(pend_bits) << (mbp_pkg::BYTE_BITS - int'(pend_cnt)));
        n = 1;
        pend_bits = '0;
        pend_cnt = '0;
      end
    end else begin
      n_bits = int'(cnt);
      if (n_bits > mbp_pkg::MAX_FIELD_BITS) n_bits = mbp_pkg::MAX_FIELD_BITS;
      if (n_bits > mbp_pkg::VALUE_BITS) n_bits = mbp_pkg::VALUE_BITS;
      acc = {1'b0, pend_bits};
      fill = int'(pend_cnt);
      for (int i = n_bits - 1; i >= 0; i--) begin
        acc = {acc[6:0], val[i]};
        fill++;
        if (fill == mbp_pkg::BYTE_BITS) begin
          got[n].data = acc;
          n++;
          acc = '0;
          fill = 0;
        end
      end
      pend_bits = acc[6:0];
      pend_cnt = 3'(fill);
    end
    for (int k = 0; k < n; k++) begin
      got[k].last = (k == n - 1);
      exp_bytes.push_back(got[k]);
    end
  endtask

  // Offer one item, possibly after a random gap, and hold it until accepted.
  task automatic send_item(input mbp_pkg::action_t act, input logic [31:0] val,
                           input logic [5:0] cnt);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    in_action <= act;
    in_field_value <= val;
    in_bit_count <= cnt;
    do @(posedge clk); while (full);
    predict_packed_bytes(act, val, cnt);
  endtask

  // Drop push and hold off until every predicted byte has been popped.
  task automatic wait_all_bytes();
    push <= 1'b0;
    do @(posedge clk); while (exp_bytes.size() != 0);
  endtask

  task automatic send_random_item();
    mbp_pkg::action_t act;
    logic [5:0]       cnt;
    int               pick;
    act = ($urandom_range(0, 7) == 0) ? mbp_pkg::ACT_FLUSH : mbp_pkg::ACT_APPEND;
    pick = $urandom_range(0, 9);
    if (pick == 0) cnt = 6'($urandom_range(33, 63));
    else if (pick == 1) cnt = ($urandom_range(0, 1) != 0) ? 6'd32 : 6'd0;
    else cnt = 6'($urandom_range(1, 32));
    send_item(act, $urandom, cnt);
  endtask

  task automatic test_directed_fields();
    send_item(mbp_pkg::ACT_APPEND, 32'hFFFF_FFFF, 6'd32);
    send_item(mbp_pkg::ACT_APPEND, 32'h0000_0000, 6'd32);
    // zero count leaves the state alone
    send_item(mbp_pkg::ACT_APPEND, 32'hFFFF_FFFF, 6'd0);
    send_item(mbp_pkg::ACT_APPEND, 32'h0000_0001, 6'd1);
    send_item(mbp_pkg::ACT_FLUSH,  32'h0000_0000, 6'd0);
    // nothing pending: no byte
    send_item(mbp_pkg::ACT_FLUSH,  32'hFFFF_FFFF, 6'd63);
    send_item(mbp_pkg::ACT_APPEND, 32'hA5A5_A5A5, 6'd33);
    send_item(mbp_pkg::ACT_APPEND, 32'h5A5A_5A5A, 6'd63);
    // upper value bits ignored
    send_item(mbp_pkg::ACT_APPEND, 32'hFFFF_FFF5, 6'd4);
    send_item(mbp_pkg::ACT_APPEND, 32'h0000_000A, 6'd4);
    send_item(mbp_pkg::ACT_APPEND, 32'hFFFF_FF7F, 6'd7);
    send_item(mbp_pkg::ACT_APPEND, 32'h0000_0001, 6'd1);
    // seven pending plus a full word gives four bytes
    send_item(mbp_pkg::ACT_APPEND, 32'h0000_0055, 6'd7);
    send_item(mbp_pkg::ACT_APPEND, 32'hDEAD_BEEF, 6'd32);
    send_item(mbp_pkg::ACT_FLUSH,  32'hFFFF_FFFF, 6'd32);
    send_item(mbp_pkg::ACT_APPEND, 32'h0000_0001, 6'd3);
    send_item(mbp_pkg::ACT_FLUSH,  32'h1234_5678, 6'd17);
    send_item(mbp_pkg::ACT_APPEND, 32'h8000_0000, 6'd32);
    send_item(mbp_pkg::ACT_APPEND, 32'h0000_007F, 6'd7);
    send_item(mbp_pkg::ACT_FLUSH,  32'h0000_0000, 6'd0);
  endtask

  task automatic test_drain_pause();
    repeat (12) send_random_item();
    wait_all_bytes();
    repeat (12) send_random_item();
    wait_all_bytes();
  endtask

  task automatic test_random_with_gaps();
    repeat (320) send_random_item();
  endtask

  task automatic test_random_back_to_back();
    gaps_on = 1'b0;
    repeat (120) send_random_item();
  endtask

  // Result side: random pop stalls while gaps are enabled.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_stall > 0) begin
      pop_stall--;
      pop <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      pop_stall = $urandom_range(1, 6) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Compare each popped byte with the oldest prediction.
  always @(posedge clk) begin
    packed_byte_t want;
    if (rst_n && pop && !empty) begin
      if (exp_bytes.size() == 0) begin
        $error("unexpected byte_out %0h with last %0b", out_byte_out, out_last);
        err_count++;
      end else begin
        want = exp_bytes.pop_front();
        if (out_byte_out !== want.data) begin
          $error("byte_out: expected %0h, actual %0h", want.data, out_byte_out);
          err_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_last);
          err_count++;
        end
      end
    end
  end

  // End the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n && !(push && !full) && !(pop && !empty)) begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end else begin
      stuck_cycles = 0;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_fields();
    test_drain_pause();
    test_random_with_gaps();
    test_random_back_to_back();
    wait_all_bytes();
    repeat (10) @(posedge clk);
    if (err_count == 0 && exp_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mbp_pkg.sv
design/mbp_front.sv
design/mbp_cmd_fifo.sv
design/mbp_back.sv
design/msb_first_bit_packer.sv
verif/tb_msb_first_bit_packer.sv
